// ===== rtl/core/mcbr_pkg.sv =====
//------------------------------------------------------------------------------
// mcbr_pkg
// Shared constants, codes and types of the menu cartridge bus responder.
//------------------------------------------------------------------------------
`default_nettype none

package mcbr_pkg;

   localparam int SCREEN_BYTES    = 1024;
   localparam int CHARSET_BYTES   = 4096;
   localparam int PROGRAM_BYTES   = 65536;
   localparam int CARTRIDGE_BYTES = 32768;

   localparam int STORE_BYTES = PROGRAM_BYTES + CARTRIDGE_BYTES + 2 * SCREEN_BYTES
                                + CHARSET_BYTES;
   localparam int STORE_AW    = $clog2(STORE_BYTES);

   localparam logic [STORE_AW-1:0] PROGRAM_BASE = '0;
   localparam logic [STORE_AW-1:0] CART_BASE    = STORE_AW'(PROGRAM_BYTES);
   localparam logic [STORE_AW-1:0] SCREEN_BASE  = STORE_AW'(PROGRAM_BYTES + CARTRIDGE_BYTES);
   localparam logic [STORE_AW-1:0] COLOR_BASE   = STORE_AW'(PROGRAM_BYTES + CARTRIDGE_BYTES
                                                            + SCREEN_BYTES);
   localparam logic [STORE_AW-1:0] CHARSET_BASE = STORE_AW'(PROGRAM_BYTES + CARTRIDGE_BYTES
                                                            + 2 * SCREEN_BYTES);

   localparam logic [15:0] SCREEN_MASK  = 16'(SCREEN_BYTES - 1);
   localparam logic [15:0] CHARSET_MASK = 16'(CHARSET_BYTES - 1);
   localparam logic [15:0] PROGRAM_MASK = 16'(PROGRAM_BYTES - 1);
   localparam logic [15:0] CART_MASK    = 16'(CARTRIDGE_BYTES - 1);

   localparam logic [1:0] CMD_READ  = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_LOAD  = 2'd2;

   localparam logic [2:0] LOAD_SCREEN  = 3'd0;
   localparam logic [2:0] LOAD_COLOR   = 3'd1;
   localparam logic [2:0] LOAD_CHARSET = 3'd2;
   localparam logic [2:0] LOAD_PROGRAM = 3'd3;
   localparam logic [2:0] LOAD_CART    = 3'd4;

   localparam logic [1:0] REG_ENABLED   = 2'd0;
   localparam logic [1:0] REG_MODE      = 2'd1;
   localparam logic [1:0] REG_PRG_SIZE  = 2'd2;
   localparam logic [1:0] REG_PRG_LOAD  = 2'd3;

   localparam logic [1:0] MODE_LAUNCHER = 2'd0;
   localparam logic [1:0] MODE_LOW_HIGH = 2'd2;

   localparam logic [15:0] ADDR_STREAM   = 16'hfde5;
   localparam logic [15:0] ADDR_END_LOW  = 16'hfde6;
   localparam logic [15:0] ADDR_END_HIGH = 16'hfde7;
   localparam logic [15:0] ADDR_ID_FIRST = 16'hfd90;
   localparam logic [15:0] ADDR_ID_LAST  = 16'hfd97;
   localparam logic [15:0] ADDR_KEY      = 16'hfd91;
   localparam logic [15:0] ROM_MASK      = 16'h3fff;

   localparam logic [7:0] MACHINE_FIRST = 8'd250;
   localparam logic [7:0] MACHINE_BIAS  = 8'd252;

   typedef enum logic [1:0] {
      REGION_SCREEN,
      REGION_COLOR,
      REGION_CHARSET,
      REGION_PROGRAM
   } mcbr_region_type;

   typedef enum logic [1:0] {
      SRC_NONE,
      SRC_CONST,
      SRC_STORE
   } mcbr_src_type;

endpackage

`default_nettype wire

// ===== rtl/core/mcbr_ram.sv =====
//------------------------------------------------------------------------------
// mcbr_ram
// Generic synchronous RAM with one write port and one registered read port.
//------------------------------------------------------------------------------
`default_nettype none

module mcbr_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/menu_cartridge_bus_responder.sv =====
//------------------------------------------------------------------------------
// menu_cartridge_bus_responder
// Answers bus cycles of a menu cartridge: buffer streaming, ROM windows,
// ID bytes, keypress and machine code writes, and host loads of the stores.
//
//   channel   ports                       transfer when
//   request   start, busy, req_*          start high and busy low
//   result    rsp_valid, rsp_*            rsp_valid high, one cycle
//   config    psel, penable, pwrite, ...  psel, penable, pwrite, pready high
//
// The store read issued at acceptance returns its registered data in the
// cycle after acceptance, when the result is shown. busy is high during that
// result cycle, so no new item is taken until its result is shown. The stores
// share one memory, have no reset and need no clearing pass; reset restores
// the registers, the transfer buffer and its offset. The result is not held:
// the receiver takes it in its single cycle.
//------------------------------------------------------------------------------
`default_nettype none

module menu_cartridge_bus_responder (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_command,
   input  wire logic [15:0] req_address,
   input  wire logic [7:0]  req_write_data,
   input  wire logic        req_bus_available,
   input  wire logic        req_low_rom_select,
   input  wire logic        req_high_rom_select,
   input  wire logic [2:0]  req_load_region,

   output logic             rsp_valid,
   output logic             rsp_drive_bus,
   output logic      [7:0]  rsp_read_data,
   output logic             rsp_key_valid,
   output logic      [7:0]  rsp_key_code,
   output logic             rsp_machine_valid,
   output logic signed [2:0] rsp_machine_type,

   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [3:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic      [31:0] prdata,
   output logic             pready
);

   logic                    busy_ff;
   logic                    cart_enabled_ff;
   logic [1:0]              cart_mode_ff;
   logic [15:0]             prg_size_ff;
   logic [15:0]             prg_load_ff;
   mcbr_pkg::mcbr_region_type region_ff, region_in;
   logic [15:0]             offset_ff, offset_in;

   mcbr_pkg::mcbr_src_type  src_ff, src_in;
   logic [7:0]              const_ff, const_in;
   logic                    key_valid_ff, key_valid_in;
   logic [7:0]              key_code_ff, key_code_in;
   logic                    mach_valid_ff, mach_valid_in;
   logic [2:0]              mach_type_ff, mach_type_in;

   logic                    accept;
   logic                    bus_read;
   logic                    bus_write;
   logic                    load;
   logic [15:0]             ofs;
   logic [15:0]             mask;
   logic [15:0]             end_addr;
   logic [14:0]             cart_index;
   logic [7:0]              mach_diff;
   logic                    cfg_write;

   logic [mcbr_pkg::STORE_AW-1:0] stream_base;
   logic [mcbr_pkg::STORE_AW-1:0] load_base;
   logic [15:0]                   load_mask;
   logic [mcbr_pkg::STORE_AW-1:0] wr_addr;
   logic [mcbr_pkg::STORE_AW-1:0] rd_addr;
   logic                          wr_store;
   logic                          rd_store;
   logic [7:0]                    q_store;

   assign accept    = start && !busy_ff;
   assign load      = accept && (req_command == mcbr_pkg::CMD_LOAD);
   assign bus_read  = accept && cart_enabled_ff && (req_command == mcbr_pkg::CMD_READ) &&
                      req_bus_available;
   assign bus_write = accept && cart_enabled_ff && (req_command == mcbr_pkg::CMD_WRITE);
   assign cfg_write = psel && penable && pwrite;
   assign end_addr  = prg_load_ff + prg_size_ff - 16'd2;
   assign mach_diff = req_write_data - mcbr_pkg::MACHINE_BIAS;
   assign cart_index = {req_high_rom_select && !req_low_rom_select,
                        req_address[13:0]} & mcbr_pkg::CART_MASK[14:0];

   always_comb begin
      case (region_ff)
         mcbr_pkg::REGION_SCREEN: begin
            mask        = mcbr_pkg::SCREEN_MASK;
            stream_base = mcbr_pkg::SCREEN_BASE;
         end
         mcbr_pkg::REGION_COLOR: begin
            mask        = mcbr_pkg::SCREEN_MASK;
            stream_base = mcbr_pkg::COLOR_BASE;
         end
         mcbr_pkg::REGION_CHARSET: begin
            mask        = mcbr_pkg::CHARSET_MASK;
            stream_base = mcbr_pkg::CHARSET_BASE;
         end
         default: begin
            mask        = mcbr_pkg::PROGRAM_MASK;
            stream_base = mcbr_pkg::PROGRAM_BASE;
         end
      endcase
   end

   always_comb begin
      case (req_load_region)
         mcbr_pkg::LOAD_SCREEN: begin
            load_mask = mcbr_pkg::SCREEN_MASK;
            load_base = mcbr_pkg::SCREEN_BASE;
         end
         mcbr_pkg::LOAD_COLOR: begin
            load_mask = mcbr_pkg::SCREEN_MASK;
            load_base = mcbr_pkg::COLOR_BASE;
         end
         mcbr_pkg::LOAD_CHARSET: begin
            load_mask = mcbr_pkg::CHARSET_MASK;
            load_base = mcbr_pkg::CHARSET_BASE;
         end
         mcbr_pkg::LOAD_PROGRAM: begin
            load_mask = mcbr_pkg::PROGRAM_MASK;
            load_base = mcbr_pkg::PROGRAM_BASE;
         end
         default: begin
            load_mask = mcbr_pkg::CART_MASK;
            load_base = mcbr_pkg::CART_BASE;
         end
      endcase
   end

   assign ofs      = offset_ff & mask;
   assign wr_store = load &&
                     (req_load_region inside {[mcbr_pkg::LOAD_SCREEN:mcbr_pkg::LOAD_CART]});
   assign wr_addr  = load_base +
                     {{(mcbr_pkg::STORE_AW-16){1'b0}}, req_address & load_mask};

   always_comb begin
      region_in     = region_ff;
      offset_in     = offset_ff;
      src_in        = mcbr_pkg::SRC_NONE;
      const_in      = 8'd0;
      key_valid_in  = 1'b0;
      key_code_in   = 8'd0;
      mach_valid_in = 1'b0;
      mach_type_in  = 3'd0;
      rd_store      = 1'b0;
      rd_addr       = '0;
      if (bus_read) begin
         if (req_address == mcbr_pkg::ADDR_STREAM) begin
            offset_in = (ofs + 16'd1) & mask;
            src_in    = mcbr_pkg::SRC_STORE;
            rd_store  = 1'b1;
            rd_addr   = stream_base + {{(mcbr_pkg::STORE_AW-16){1'b0}}, ofs};
         end else if (req_address == mcbr_pkg::ADDR_END_LOW) begin
            src_in   = mcbr_pkg::SRC_CONST;
            const_in = end_addr[7:0];
         end else if (req_address == mcbr_pkg::ADDR_END_HIGH) begin
            src_in   = mcbr_pkg::SRC_CONST;
            const_in = end_addr[15:8];
         end else if (req_low_rom_select ||
                      (req_high_rom_select && cart_mode_ff == mcbr_pkg::MODE_LOW_HIGH)) begin
            src_in   = mcbr_pkg::SRC_STORE;
            rd_store = 1'b1;
            rd_addr  = mcbr_pkg::CART_BASE +
                       {{(mcbr_pkg::STORE_AW-15){1'b0}}, cart_index};
         end else if (req_address inside
                      {[mcbr_pkg::ADDR_ID_FIRST:mcbr_pkg::ADDR_ID_LAST]}) begin
            src_in   = mcbr_pkg::SRC_CONST;
            const_in = {5'd0, req_address[2:0]} +
                       ((cart_mode_ff == mcbr_pkg::MODE_LAUNCHER) ? 8'd0 : 8'd1);
         end
      end else if (bus_write) begin
         if (req_address == mcbr_pkg::ADDR_KEY) begin
            key_valid_in = 1'b1;
            key_code_in  = req_write_data;
         end else if (req_address == mcbr_pkg::ADDR_STREAM) begin
            if (req_write_data >= mcbr_pkg::MACHINE_FIRST) begin
               mach_valid_in = 1'b1;
               mach_type_in  = mach_diff[2:0];
            end else begin
               offset_in = 16'd0;
               if (req_write_data <= 8'(mcbr_pkg::REGION_CHARSET)) begin
                  region_in = mcbr_pkg::mcbr_region_type'(req_write_data[1:0]);
               end else begin
                  region_in = mcbr_pkg::REGION_PROGRAM;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff         <= 1'b0;
         cart_enabled_ff <= 1'b1;
         cart_mode_ff    <= mcbr_pkg::MODE_LAUNCHER;
         prg_size_ff     <= 16'd0;
         prg_load_ff     <= 16'd0;
         region_ff       <= mcbr_pkg::REGION_SCREEN;
         offset_ff       <= 16'd0;
      end else begin
         busy_ff   <= accept;
         region_ff <= region_in;
         offset_ff <= offset_in;
         if (cfg_write) begin
            case (paddr[3:2])
               mcbr_pkg::REG_ENABLED:  cart_enabled_ff <= pwdata[0];
               mcbr_pkg::REG_MODE:     cart_mode_ff    <= pwdata[1:0];
               mcbr_pkg::REG_PRG_SIZE: prg_size_ff     <= pwdata[15:0];
               mcbr_pkg::REG_PRG_LOAD: prg_load_ff     <= pwdata[15:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         src_ff        <= src_in;
         const_ff      <= const_in;
         key_valid_ff  <= key_valid_in;
         key_code_ff   <= key_code_in;
         mach_valid_ff <= mach_valid_in;
         mach_type_ff  <= mach_type_in;
      end
   end

   mcbr_ram #(.DEPTH(mcbr_pkg::STORE_BYTES), .WIDTH(8)) u_store (
      .clock   (clock),
      .wr_en   (wr_store),
      .wr_addr (wr_addr),
      .wr_data (req_write_data),
      .rd_en   (rd_store),
      .rd_addr (rd_addr),
      .rd_data (q_store)
   );

   always_comb begin
      case (src_ff)
         mcbr_pkg::SRC_CONST: rsp_read_data = const_ff;
         mcbr_pkg::SRC_STORE: rsp_read_data = q_store;
         default:             rsp_read_data = 8'd0;
      endcase
   end

   always_comb begin
      case (paddr[3:2])
         mcbr_pkg::REG_ENABLED:  prdata = {31'd0, cart_enabled_ff};
         mcbr_pkg::REG_MODE:     prdata = {30'd0, cart_mode_ff};
         mcbr_pkg::REG_PRG_SIZE: prdata = {16'd0, prg_size_ff};
         mcbr_pkg::REG_PRG_LOAD: prdata = {16'd0, prg_load_ff};
         default:                prdata = 32'd0;
      endcase
   end

   assign busy              = busy_ff;
   assign pready            = 1'b1;
   assign rsp_valid         = busy_ff;
   assign rsp_drive_bus     = (src_ff != mcbr_pkg::SRC_NONE);
   assign rsp_key_valid     = key_valid_ff;
   assign rsp_key_code      = key_code_ff;
   assign rsp_machine_valid = mach_valid_ff;
   assign rsp_machine_type  = mach_type_ff;

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> rsp_valid)
      else $error("accepted transfer produced no result");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe lasted more than one cycle");

   a_one_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0({rsp_drive_bus, rsp_key_valid, rsp_machine_valid}))
      else $error("result carries more than one kind of response");

   a_quiet_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_drive_bus) |-> (rsp_read_data == 8'd0))
      else $error("read data not zero while bus is not driven");

endmodule

`default_nettype wire

// ===== sim/tb_menu_cartridge_bus_responder.sv =====
//------------------------------------------------------------------------------
// tb_menu_cartridge_bus_responder
// Self-checking testbench for the menu cartridge bus responder. Bus cycles
// and host loads go in through the start/busy command port. A predictor with
// its own copy of the registers, the transfer buffer state and the stores
// works out the answer to every accepted transfer. A monitor compares each
// result strobe, field by field, with the oldest pending answer. Stimulus runs
// directed cases, a full buffer wrap, the ROM windows in the non-launcher
// modes, a disabled cart and random traffic under several register settings
// and sender idle levels. Store entries are always loaded before they are read.
//------------------------------------------------------------------------------
`default_nettype none

module tb_menu_cartridge_bus_responder;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0]  CMD_UNUSED        = 2'd3;
   localparam logic [2:0]  LOAD_UNUSED_FIRST = 3'd5;
   localparam logic [2:0]  LOAD_UNUSED_LAST  = 3'd7;
   localparam logic [1:0]  MODE_LOW_ONLY     = 2'd1;
   localparam logic [1:0]  MODE_UNUSED       = 2'd3;
   localparam logic [15:0] ROM_HIGH_BASE     = 16'h4000;

   localparam int STORE_TOTAL     = 2 * mcbr_pkg::SCREEN_BYTES + mcbr_pkg::CHARSET_BYTES
                                    + mcbr_pkg::PROGRAM_BYTES + mcbr_pkg::CARTRIDGE_BYTES;
   localparam int SETTLE_CYCLES   = 4;
   localparam int WATCHDOG_CYCLES = 2000;
   localparam int MAX_REPORTS     = 50;
   localparam int MIX_LENGTH      = 32;

   typedef struct packed {
      logic [1:0]  command;
      logic [15:0] address;
      logic [7:0]  data;
      logic        avail;
      logic        lo_sel;
      logic        hi_sel;
      logic [2:0]  region;
   } bus_item_type;

   typedef struct packed {
      logic              drive;
      logic [7:0]        rdata;
      logic              kvalid;
      logic [7:0]        kcode;
      logic              mvalid;
      logic signed [2:0] mtype;
   } bus_answer_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_command = '0;
   logic [15:0] req_address = '0;
   logic [7:0]  req_write_data = '0;
   logic        req_bus_available = 1'b0;
   logic        req_low_rom_select = 1'b0;
   logic        req_high_rom_select = 1'b0;
   logic [2:0]  req_load_region = '0;
   logic        rsp_valid;
   logic        rsp_drive_bus;
   logic [7:0]  rsp_read_data;
   logic        rsp_key_valid;
   logic [7:0]  rsp_key_code;
   logic        rsp_machine_valid;
   logic signed [2:0] rsp_machine_type;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [3:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   logic                      cfg_enabled = 1'b1;
   logic [1:0]                cfg_mode = mcbr_pkg::MODE_LAUNCHER;
   logic [15:0]               cfg_prg_size = '0;
   logic [15:0]               cfg_prg_load = '0;
   mcbr_pkg::mcbr_region_type buf_region = mcbr_pkg::REGION_SCREEN;
   logic [15:0]               buf_offset = '0;
   logic [7:0]                store_mem [STORE_TOTAL];
   bit                        store_written [STORE_TOTAL];

   bus_answer_type answer_queue [$];
   int idle_pct = 0;
   int items_sent = 0;
   int answers_checked = 0;
   int error_count = 0;
   int stall_cycles = 0;

   menu_cartridge_bus_responder dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_command         (req_command),
      .req_address         (req_address),
      .req_write_data      (req_write_data),
      .req_bus_available   (req_bus_available),
      .req_low_rom_select  (req_low_rom_select),
      .req_high_rom_select (req_high_rom_select),
      .req_load_region     (req_load_region),
      .rsp_valid           (rsp_valid),
      .rsp_drive_bus       (rsp_drive_bus),
      .rsp_read_data       (rsp_read_data),
      .rsp_key_valid       (rsp_key_valid),
      .rsp_key_code        (rsp_key_code),
      .rsp_machine_valid   (rsp_machine_valid),
      .rsp_machine_type    (rsp_machine_type),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .prdata              (prdata),
      .pready              (pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic bus_item_type bus_item(input logic [1:0] command,
                                             input logic [15:0] address,
                                             input logic [7:0] data, input logic avail,
                                             input logic lo_sel, input logic hi_sel,
                                             input logic [2:0] region);
      return {command, address, data, avail, lo_sel, hi_sel, region};
   endfunction

   function automatic int region_bytes(input logic [2:0] region);
      case (region)
         mcbr_pkg::LOAD_SCREEN, mcbr_pkg::LOAD_COLOR: return mcbr_pkg::SCREEN_BYTES;
         mcbr_pkg::LOAD_CHARSET:                      return mcbr_pkg::CHARSET_BYTES;
         mcbr_pkg::LOAD_PROGRAM:                      return mcbr_pkg::PROGRAM_BYTES;
         default:                                     return mcbr_pkg::CARTRIDGE_BYTES;
      endcase
   endfunction

   function automatic int store_index(input logic [2:0] region, input logic [15:0] offset);
      int base;
      case (region)
         mcbr_pkg::LOAD_SCREEN:  base = 0;
         mcbr_pkg::LOAD_COLOR:   base = mcbr_pkg::SCREEN_BYTES;
         mcbr_pkg::LOAD_CHARSET: base = 2 * mcbr_pkg::SCREEN_BYTES;
         mcbr_pkg::LOAD_PROGRAM: base = 2 * mcbr_pkg::SCREEN_BYTES + mcbr_pkg::CHARSET_BYTES;
         default:                base = 2 * mcbr_pkg::SCREEN_BYTES + mcbr_pkg::CHARSET_BYTES
                                        + mcbr_pkg::PROGRAM_BYTES;
      endcase
      return base + int'(offset) % region_bytes(region);
   endfunction

   // Tells whether a transfer reads a store entry under the current state, and which one.
   function automatic bit reads_store(input bus_item_type it, output logic [2:0] region,
                                      output logic [15:0] offset);
      region = mcbr_pkg::LOAD_CART;
      offset = '0;
      if (it.command != mcbr_pkg::CMD_READ || !cfg_enabled || !it.avail) return 1'b0;
      if (it.address == mcbr_pkg::ADDR_STREAM) begin
         region = 3'(buf_region);
         offset = buf_offset;
         return 1'b1;
      end
      if (it.address == mcbr_pkg::ADDR_END_LOW || it.address == mcbr_pkg::ADDR_END_HIGH) begin
         return 1'b0;
      end
      if (it.lo_sel) begin
         offset = it.address & mcbr_pkg::ROM_MASK;
         return 1'b1;
      end
      if (it.hi_sel && cfg_mode == mcbr_pkg::MODE_LOW_HIGH) begin
         offset = ROM_HIGH_BASE + (it.address & mcbr_pkg::ROM_MASK);
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic bus_answer_type predict_answer(input bus_item_type it);
      bus_answer_type answer;
      logic [2:0]     region;
      logic [15:0]    offset;
      logic [15:0]    image_end;
      answer = '0;
      if (it.command == mcbr_pkg::CMD_LOAD) begin
         if (it.region <= mcbr_pkg::LOAD_CART) begin
            store_mem[store_index(it.region, it.address)] = it.data;
            store_written[store_index(it.region, it.address)] = 1'b1;
         end
      end else if (it.command == mcbr_pkg::CMD_READ && cfg_enabled && it.avail) begin
         if (reads_store(it, region, offset)) begin
            answer.drive = 1'b1;
            answer.rdata = store_mem[store_index(region, offset)];
            if (it.address == mcbr_pkg::ADDR_STREAM) begin
               buf_offset = 16'((int'(offset) + 1) % region_bytes(region));
            end
         end else if (it.address == mcbr_pkg::ADDR_END_LOW ||
                      it.address == mcbr_pkg::ADDR_END_HIGH) begin
            image_end = cfg_prg_load + cfg_prg_size - 16'd2;
            answer.drive = 1'b1;
            answer.rdata = (it.address == mcbr_pkg::ADDR_END_LOW) ? image_end[7:0]
                                                                  : image_end[15:8];
         end else if (it.address >= mcbr_pkg::ADDR_ID_FIRST &&
                      it.address <= mcbr_pkg::ADDR_ID_LAST) begin
            answer.drive = 1'b1;
            answer.rdata = 8'(it.address - mcbr_pkg::ADDR_ID_FIRST)
                           + ((cfg_mode == mcbr_pkg::MODE_LAUNCHER) ? 8'd0 : 8'd1);
         end
      end else if (it.command == mcbr_pkg::CMD_WRITE && cfg_enabled) begin
         if (it.address == mcbr_pkg::ADDR_KEY) begin
            answer.kvalid = 1'b1;
            answer.kcode = it.data;
         end else if (it.address == mcbr_pkg::ADDR_STREAM) begin
            if (it.data >= mcbr_pkg::MACHINE_FIRST) begin
               answer.mvalid = 1'b1;
               answer.mtype = 3'(it.data - mcbr_pkg::MACHINE_BIAS);
            end else begin
               buf_region = (it.data <= 8'(mcbr_pkg::REGION_CHARSET))
                            ? mcbr_pkg::mcbr_region_type'(it.data[1:0])
                            : mcbr_pkg::REGION_PROGRAM;
               buf_offset = '0;
            end
         end
      end
      return answer;
   endfunction

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      if (error_count < MAX_REPORTS) begin
         $display("Mismatch at %0t: %s got %0h, expected %0h", $realtime, what, got, want);
      end
      error_count++;
   endtask

   task automatic check_field(input string what, input logic [7:0] got, input logic [7:0] want);
      if (got !== want) report_mismatch(what, got, want);
   endtask

   always @(posedge clock) begin
      bus_answer_type want;
      if (!reset) begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
               mcbr_pkg::REG_ENABLED:  cfg_enabled = pwdata[0];
               mcbr_pkg::REG_MODE:     cfg_mode = pwdata[1:0];
               mcbr_pkg::REG_PRG_SIZE: cfg_prg_size = pwdata[15:0];
               mcbr_pkg::REG_PRG_LOAD: cfg_prg_load = pwdata[15:0];
               default: ;
            endcase
         end
         if (start && !busy) begin
            answer_queue.push_back(predict_answer(bus_item(req_command, req_address,
               req_write_data, req_bus_available, req_low_rom_select, req_high_rom_select,
               req_load_region)));
         end
         if (rsp_valid) begin
            if (answer_queue.size() == 0) begin
               report_mismatch("result with no pending transfer", rsp_read_data, 8'h00);
            end else begin
               want = answer_queue.pop_front();
               answers_checked++;
               check_field("drive_bus", 8'(rsp_drive_bus), 8'(want.drive));
               check_field("read_data", rsp_read_data, want.rdata);
               check_field("key_valid", 8'(rsp_key_valid), 8'(want.kvalid));
               check_field("key_code", rsp_key_code, want.kcode);
               check_field("machine_valid", 8'(rsp_machine_valid), 8'(want.mvalid));
               check_field("machine_type", 8'(rsp_machine_type), 8'(want.mtype));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (psel && penable)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= WATCHDOG_CYCLES) begin
         $display("Timeout: no transfer for %0d cycles, %0d results pending",
                  WATCHDOG_CYCLES, answer_queue.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic send_bus_item(input bus_item_type it);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_command <= it.command;
      req_address <= it.address;
      req_write_data <= it.data;
      req_bus_available <= it.avail;
      req_low_rom_select <= it.lo_sel;
      req_high_rom_select <= it.hi_sel;
      req_load_region <= it.region;
      do @(posedge clock); while (busy);
      items_sent++;
      @(negedge clock);
   endtask

   // Loads a store entry first when the transfer would read one never written.
   task automatic send_checked(input bus_item_type it);
      logic [2:0]  region;
      logic [15:0] offset;
      logic [15:0] spare;
      if (reads_store(it, region, offset) && !store_written[store_index(region, offset)]) begin
         spare = 16'($urandom) & ~16'(region_bytes(region) - 1);
         send_bus_item(bus_item(mcbr_pkg::CMD_LOAD, offset | spare, 8'($urandom),
                                1'($urandom), 1'($urandom), 1'($urandom), region));
      end
      send_bus_item(it);
   endtask

   task automatic bus_read(input logic [15:0] address, input logic lo_sel = 1'b0,
                           input logic hi_sel = 1'b0, input logic avail = 1'b1);
      send_checked(bus_item(mcbr_pkg::CMD_READ, address, 8'($urandom), avail, lo_sel, hi_sel,
                            3'($urandom)));
   endtask

   task automatic bus_write(input logic [15:0] address, input logic [7:0] data);
      send_checked(bus_item(mcbr_pkg::CMD_WRITE, address, data, 1'($urandom), 1'($urandom),
                            1'($urandom), 3'($urandom)));
   endtask

   task automatic host_load(input logic [2:0] region, input logic [15:0] address,
                            input logic [7:0] data);
      send_checked(bus_item(mcbr_pkg::CMD_LOAD, address, data, 1'($urandom), 1'($urandom),
                            1'($urandom), region));
   endtask

   task automatic settle_block();
      start <= 1'b0;
      @(negedge clock);
      while (answer_queue.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(input logic [1:0] index, input logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {index, 2'b00};
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(negedge clock);
   endtask

   function automatic logic [1:0] mode_choice(input int k);
      case (k % 4)
         0:       return mcbr_pkg::MODE_LAUNCHER;
         1:       return MODE_LOW_ONLY;
         2:       return mcbr_pkg::MODE_LOW_HIGH;
         default: return MODE_UNUSED;
      endcase
   endfunction

   function automatic logic [15:0] pick_extreme16();
      case ($urandom_range(2))
         0:       return 16'h0000;
         1:       return 16'hffff;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_random_mix(input int count);
      int done;
      int pick;
      int burst;
      done = 0;
      while (done < count) begin
         pick = $urandom_range(99);
         if (pick < 25) begin
            bus_write(mcbr_pkg::ADDR_STREAM, $urandom_range(1) ? 8'($urandom_range(2))
                                                               : 8'($urandom_range(3, 249)));
            burst = $urandom_range(1, 8);
            repeat (burst) begin
               bus_read(mcbr_pkg::ADDR_STREAM, 1'($urandom), 1'($urandom),
                        $urandom_range(9) != 0);
            end
            done += burst + 1;
         end else begin
            if (pick < 40) begin
               bus_read(16'($urandom), 1'($urandom), 1'($urandom), $urandom_range(9) != 0);
            end else if (pick < 50) begin
               bus_read(16'(mcbr_pkg::ADDR_ID_FIRST + $urandom_range(9) - 1),
                        $urandom_range(3) == 0, 1'($urandom), $urandom_range(9) != 0);
            end else if (pick < 58) begin
               bus_read($urandom_range(1) ? mcbr_pkg::ADDR_END_LOW : mcbr_pkg::ADDR_END_HIGH,
                        1'($urandom), 1'($urandom), $urandom_range(9) != 0);
            end else if (pick < 66) begin
               bus_write(mcbr_pkg::ADDR_KEY, 8'($urandom));
            end else if (pick < 72) begin
               bus_write(mcbr_pkg::ADDR_STREAM, 8'($urandom_range(250, 255)));
            end else if (pick < 82) begin
               host_load($urandom_range(9) == 0 ? 3'($urandom) : 3'($urandom_range(4)),
                         16'($urandom), 8'($urandom));
            end else begin
               send_checked(bus_item(2'($urandom), 16'($urandom), 8'($urandom), 1'($urandom),
                                     1'($urandom), 1'($urandom), 3'($urandom)));
            end
            done++;
         end
      end
   endtask

   task automatic test_directed_cases();
      idle_pct = 0;
      bus_read(mcbr_pkg::ADDR_ID_FIRST);
      bus_read(mcbr_pkg::ADDR_ID_LAST);
      bus_read(mcbr_pkg::ADDR_END_LOW);
      bus_read(mcbr_pkg::ADDR_END_HIGH);
      bus_write(mcbr_pkg::ADDR_KEY, 8'h00);
      send_checked(bus_item(mcbr_pkg::CMD_WRITE, mcbr_pkg::ADDR_KEY, 8'hff, 1'b0, 1'b1, 1'b1,
                            mcbr_pkg::LOAD_CART));
      bus_write(mcbr_pkg::ADDR_STREAM, mcbr_pkg::MACHINE_FIRST);
      bus_write(mcbr_pkg::ADDR_STREAM, 8'hff);
      host_load(mcbr_pkg::LOAD_SCREEN, 16'hfc00, 8'ha5);
      bus_read(mcbr_pkg::ADDR_STREAM);
      bus_read(mcbr_pkg::ADDR_STREAM, 1'b0, 1'b0, 1'b0);
      bus_write(mcbr_pkg::ADDR_STREAM, 8'(mcbr_pkg::REGION_COLOR));
      bus_read(mcbr_pkg::ADDR_STREAM);
      bus_write(mcbr_pkg::ADDR_STREAM, 8'(mcbr_pkg::REGION_CHARSET));
      bus_read(mcbr_pkg::ADDR_STREAM);
      bus_write(mcbr_pkg::ADDR_STREAM, 8'd249);
      bus_read(mcbr_pkg::ADDR_STREAM);
      bus_write(mcbr_pkg::ADDR_STREAM, 8'(mcbr_pkg::REGION_PROGRAM));
      bus_read(mcbr_pkg::ADDR_STREAM, 1'b1, 1'b1);
      bus_write(mcbr_pkg::ADDR_STREAM, 8'(mcbr_pkg::REGION_SCREEN));
      bus_read(16'h0000, 1'b1);
      bus_read(16'hffff, 1'b1);
      bus_read(16'hffff, 1'b0, 1'b1);
      bus_read(16'hfd95, 1'b0, 1'b1);
      bus_write(16'h1234, 8'h77);
      send_checked(bus_item(CMD_UNUSED, mcbr_pkg::ADDR_STREAM, 8'hff, 1'b1, 1'b1, 1'b1,
                            mcbr_pkg::LOAD_CART));
      host_load(LOAD_UNUSED_FIRST, 16'h0000, 8'h11);
      host_load(LOAD_UNUSED_LAST, 16'hffff, 8'h22);
      host_load(mcbr_pkg::LOAD_CART, 16'hffff, 8'hff);
      bus_read(16'hfd98);
      bus_read(16'hfd8f);
      settle_block();
   endtask

   task automatic test_stream_wrap();
      idle_pct = 0;
      bus_write(mcbr_pkg::ADDR_STREAM, 8'(mcbr_pkg::REGION_SCREEN));
      repeat (mcbr_pkg::SCREEN_BYTES + 1) bus_read(mcbr_pkg::ADDR_STREAM);
      settle_block();
   endtask

   task automatic test_rom_windows();
      idle_pct = 79;
      for (int k = 1; k < 4; k++) begin
         write_register(mcbr_pkg::REG_MODE, 32'(mode_choice(k)));
         bus_read(16'h0000, 1'b1);
         bus_read(16'hffff, 1'b0, 1'b1);
         bus_read(16'h0000, 1'b0, 1'b1);
         bus_read(16'($urandom), 1'b1, 1'b1);
         bus_read(mcbr_pkg::ADDR_ID_FIRST);
         bus_read(mcbr_pkg::ADDR_ID_LAST);
         bus_read(mcbr_pkg::ADDR_ID_LAST, 1'b0, 1'b1);
         repeat (6) bus_read(16'($urandom), 1'($urandom), 1'($urandom));
         settle_block();
      end
      write_register(mcbr_pkg::REG_MODE, 32'(mcbr_pkg::MODE_LAUNCHER));
   endtask

   task automatic test_disabled_cart();
      idle_pct = 9;
      write_register(mcbr_pkg::REG_ENABLED, 32'd0);
      bus_read(mcbr_pkg::ADDR_STREAM);
      bus_read(mcbr_pkg::ADDR_ID_FIRST);
      bus_read(mcbr_pkg::ADDR_END_LOW);
      bus_read(16'h0000, 1'b1);
      bus_write(mcbr_pkg::ADDR_KEY, 8'h5a);
      bus_write(mcbr_pkg::ADDR_STREAM, mcbr_pkg::MACHINE_FIRST);
      bus_write(mcbr_pkg::ADDR_STREAM, 8'(mcbr_pkg::REGION_COLOR));
      host_load(mcbr_pkg::LOAD_SCREEN, 16'h0000, 8'h3c);
      send_random_mix(30);
      settle_block();
      write_register(mcbr_pkg::REG_ENABLED, 32'd1);
      repeat (4) bus_read(mcbr_pkg::ADDR_STREAM);
      settle_block();
   endtask

   task automatic test_random_traffic();
      for (int phase = 0; phase < 3; phase++) begin
         idle_pct = (phase == 0) ? 0 : (phase == 1) ? 79 : 9;
         for (int k = 0; k < 4; k++) begin
            write_register(mcbr_pkg::REG_MODE, 32'(mode_choice(k + phase)));
            write_register(mcbr_pkg::REG_PRG_SIZE, 32'(pick_extreme16()));
            write_register(mcbr_pkg::REG_PRG_LOAD, 32'(pick_extreme16()));
            send_random_mix(MIX_LENGTH);
            settle_block();
         end
      end
   endtask

   initial begin
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_stream_wrap();
      test_rom_windows();
      test_disabled_cart();
      test_random_traffic();
      settle_block();
      $display("Run covered %0d accepted transfers and %0d checked results.",
               items_sent, answers_checked);
      $display("Tests: directed cases, buffer wrap, ROM windows, disabled cart, random mix.");
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

`default_nettype wire
